FILE: rtl/core/bpa_pkg.sv
// Shared package of the bitmap page allocator: field widths, codes,
// transaction structs and the controller-to-datapath command and status types.
// Depends on nothing.
package bpa_pkg;

  localparam int MaxBlocksDef  = 64;
  localparam int PagesPerBlock = 512;
  localparam int WordW         = 64;
  localparam int WordsPerBlock = PagesPerBlock / WordW;
  localparam int WordSelW      = $clog2(WordsPerBlock);
  localparam int BitW          = $clog2(PagesPerBlock);
  localparam int ModeW         = 2;
  localparam int CountW        = 16;
  localparam int PageW         = 52;
  localparam int FrameW        = 43;
  localparam int StatusW       = 2;
  localparam int RunW          = BitW + 1;
  localparam int BlocksW       = 8;

  localparam logic [ModeW-1:0] MODE_PAGES  = 2'd0;
  localparam logic [ModeW-1:0] MODE_BLOCKS = 2'd1;
  localparam logic [ModeW-1:0] MODE_FREE   = 2'd2;

  localparam logic [StatusW-1:0] STATUS_DONE      = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd1;
  localparam logic [StatusW-1:0] STATUS_TOO_LARGE = 2'd2;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] page_count;
    logic [PageW-1:0]  page_address;
    logic [FrameW-1:0] spare_block;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PageW-1:0]   granted_page;
    logic               used_spare;
  } rsp_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_DECODE,
    CMD_SCAN_RD,
    CMD_SCAN_CAP,
    CMD_SCAN_CHUNK,
    CMD_BASE_RD,
    CMD_GRANT,
    CMD_MARK_RD,
    CMD_MARK_WR,
    CMD_ROOM,
    CMD_POS_RD,
    CMD_POS_CHK,
    CMD_COPY_RD,
    CMD_COPY_WR,
    CMD_FILL,
    CMD_BS_RD,
    CMD_BS_CMP,
    CMD_PUBLISH
  } cmd_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             reject;
    logic             count_zero;
    logic             chunk_found;
    logic             sub_last;
    logic             word_last;
    logic             blk_last;
    logic             no_room;
    logic             pos_at_end;
    logic             pos_hit;
    logic             shift_done;
    logic             fill_last;
    logic             bs_empty;
    logic             bs_equal;
    logic             free_empty;
    logic             mark_last;
    logic             out_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/bpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bpa_ram #(
  parameter int Width = 64,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bpa_ctrl.sv
// Sequencer of the bitmap page allocator: walks each request through its
// steps and issues one datapath command per cycle. Depends on bpa_pkg.
module bpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bpa_pkg::dp_status_t status_i,
  output bpa_pkg::cmd_e       cmd_o,
  output logic                in_stall_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_SRD, S_SCAP, S_SCHK, S_GRD, S_GCAP, S_MRD, S_MWR,
    S_ROOM, S_PSTART, S_PCHK, S_CSTART, S_CRD, S_CWR, S_FWR, S_BCHK, S_BCMP,
    S_FINISH
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = bpa_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = bpa_pkg::CMD_CAPTURE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o = bpa_pkg::CMD_DECODE;
        case (status_i.mode)
          bpa_pkg::MODE_PAGES: begin
            if (status_i.reject) state_d = S_FINISH;
            else if (status_i.count_zero) state_d = S_ROOM;
            else state_d = S_SRD;
          end
          bpa_pkg::MODE_BLOCKS: begin
            state_d = status_i.reject ? S_FINISH : S_PSTART;
          end
          bpa_pkg::MODE_FREE: state_d = S_BCHK;
          default: state_d = S_FINISH;
        endcase
      end
      S_SRD: begin
        cmd_o   = bpa_pkg::CMD_SCAN_RD;
        state_d = S_SCAP;
      end
      S_SCAP: begin
        cmd_o   = bpa_pkg::CMD_SCAN_CAP;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        cmd_o = bpa_pkg::CMD_SCAN_CHUNK;
        if (status_i.chunk_found) begin
          state_d = S_GRD;
        end else if (status_i.sub_last) begin
          state_d = (status_i.word_last && status_i.blk_last) ? S_ROOM : S_SRD;
        end
      end
      S_GRD: begin
        cmd_o   = bpa_pkg::CMD_BASE_RD;
        state_d = S_GCAP;
      end
      S_GCAP: begin
        cmd_o   = bpa_pkg::CMD_GRANT;
        state_d = S_MRD;
      end
      S_MRD: begin
        cmd_o   = bpa_pkg::CMD_MARK_RD;
        state_d = S_MWR;
      end
      S_MWR: begin
        cmd_o   = bpa_pkg::CMD_MARK_WR;
        state_d = status_i.mark_last ? S_FINISH : S_MRD;
      end
      S_ROOM: begin
        cmd_o   = bpa_pkg::CMD_ROOM;
        state_d = status_i.no_room ? S_FINISH : S_PSTART;
      end
      S_PSTART: begin
        cmd_o   = bpa_pkg::CMD_POS_RD;
        state_d = status_i.pos_at_end ? S_CSTART : S_PCHK;
      end
      S_PCHK: begin
        cmd_o   = bpa_pkg::CMD_POS_CHK;
        state_d = status_i.pos_hit ? S_CSTART : S_PSTART;
      end
      S_CSTART: begin
        state_d = status_i.shift_done ? S_FWR : S_CRD;
      end
      S_CRD: begin
        cmd_o   = bpa_pkg::CMD_COPY_RD;
        state_d = S_CWR;
      end
      S_CWR: begin
        cmd_o   = bpa_pkg::CMD_COPY_WR;
        state_d = status_i.word_last ? S_CSTART : S_CRD;
      end
      S_FWR: begin
        cmd_o = bpa_pkg::CMD_FILL;
        if (status_i.fill_last) state_d = S_FINISH;
      end
      S_BCHK: begin
        cmd_o   = bpa_pkg::CMD_BS_RD;
        state_d = status_i.bs_empty ? S_FINISH : S_BCMP;
      end
      S_BCMP: begin
        cmd_o = bpa_pkg::CMD_BS_CMP;
        if (status_i.bs_equal) begin
          state_d = status_i.free_empty ? S_FINISH : S_MRD;
        end else begin
          state_d = S_BCHK;
        end
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o   = bpa_pkg::CMD_PUBLISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: rtl/core/bpa_datapath.sv
// Datapath of the bitmap page allocator: request and result registers, scan,
// search and copy counters, and the block table and page map memories.
// Depends on bpa_pkg and bpa_ram.
module bpa_datapath #(
  parameter int MaxBlocks = bpa_pkg::MaxBlocksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpa_pkg::cmd_e       cmd_i,
  input  bpa_pkg::req_t       in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output bpa_pkg::rsp_t       out_data_o,
  output bpa_pkg::dp_status_t status_o
);

  localparam int IdxW    = $clog2(MaxBlocks);
  localparam int CntW    = $clog2(MaxBlocks + 1);
  localparam int UAddrW  = IdxW + bpa_pkg::WordSelW;
  localparam int SumW    = ((CntW > bpa_pkg::BlocksW) ? CntW : bpa_pkg::BlocksW) + 1;
  localparam int BitW    = bpa_pkg::BitW;
  localparam int WSelW   = bpa_pkg::WordSelW;
  localparam int WordW   = bpa_pkg::WordW;
  localparam int FrameW  = bpa_pkg::FrameW;
  localparam int RunW    = bpa_pkg::RunW;
  localparam int SubW    = 3;
  localparam int ChunkW  = 8;

  // Signed one at the width of the search bounds.
  localparam logic signed [CntW:0] BsOne = $signed((CntW + 1)'(1));

  bpa_pkg::req_t req_q;
  bpa_pkg::rsp_t res_q, out_q;
  logic          out_valid_q;

  logic [CntW-1:0]   count_q, blk_q, i_q, pos_q, sh_q;
  logic [WSelW-1:0]  wrd_q, mw_q;
  logic [SubW-1:0]   sub_q;
  logic [RunW-1:0]   run_q;
  logic [WordW-1:0]  word_q;
  logic [BitW-1:0]   lo_bit_q, hi_bit_q;
  logic              set_q;
  logic [IdxW-1:0]   tgt_q;
  logic [bpa_pkg::BlocksW-1:0] k_q;
  logic signed [CntW:0] bs_lo_q, bs_hi_q, mid_q;

  // Memory ports.
  logic              b_we, u_we;
  logic [IdxW-1:0]   b_waddr, b_raddr;
  logic [FrameW-1:0] b_wdata, b_rdata;
  logic [UAddrW-1:0] u_waddr, u_raddr;
  logic [WordW-1:0]  u_wdata, u_rdata;

  // Request decode.
  logic [bpa_pkg::CountW-1:0] pages;
  logic [RunW-1:0]            pages_run;
  logic [bpa_pkg::CountW:0]   ceil_sum;
  logic [bpa_pkg::BlocksW-1:0] n_v;
  logic [SumW-1:0]            room_sum;
  logic                       no_room, bad_small;
  logic [bpa_pkg::StatusW-1:0] decode_status;
  logic [FrameW-1:0]          frame, spare;

  assign pages     = req_q.page_count;
  assign pages_run = pages[RunW-1:0];
  assign spare     = req_q.spare_block;
  assign frame     = req_q.page_address[bpa_pkg::PageW-1:BitW];
  assign ceil_sum  = {1'b0, pages} + (bpa_pkg::CountW + 1)'(bpa_pkg::PagesPerBlock - 1);
  assign n_v       = (req_q.mode == bpa_pkg::MODE_BLOCKS) ?
                     ceil_sum[BitW +: bpa_pkg::BlocksW] : bpa_pkg::BlocksW'(1);
  assign room_sum  = SumW'(count_q) + SumW'(n_v);
  assign no_room   = room_sum > SumW'(MaxBlocks);
  assign bad_small = (pages == '0) ||
                     (pages > bpa_pkg::CountW'(bpa_pkg::PagesPerBlock));

  always_comb begin
    case (req_q.mode)
      bpa_pkg::MODE_PAGES:
        decode_status = bad_small ? bpa_pkg::STATUS_TOO_LARGE : bpa_pkg::STATUS_DONE;
      bpa_pkg::MODE_BLOCKS: begin
        if (n_v == '0) decode_status = bpa_pkg::STATUS_TOO_LARGE;
        else if (no_room) decode_status = bpa_pkg::STATUS_FULL;
        else decode_status = bpa_pkg::STATUS_DONE;
      end
      bpa_pkg::MODE_FREE: decode_status = bpa_pkg::STATUS_DONE;
      default: decode_status = bpa_pkg::STATUS_TOO_LARGE;
    endcase
  end

  // Eight bits of the first-fit run count per cycle.
  logic [RunW-1:0] run_v;
  logic            fnd_v;
  logic [BitW-1:0] j_v, start_v;

  always_comb begin
    run_v = run_q;
    fnd_v = 1'b0;
    j_v   = '0;
    for (int k = 0; k < ChunkW; k++) begin
      if (!fnd_v) begin
        run_v = word_q[{sub_q, 3'(k)}] ? '0 : run_v + RunW'(1);
        if (run_v == pages_run) begin
          fnd_v = 1'b1;
          j_v   = {wrd_q, sub_q, 3'(k)};
        end
      end
    end
  end

  assign start_v = BitW'((RunW'(j_v) + RunW'(1)) - pages_run);

  // Bit masks for marking, clearing and filling one word.
  logic [WordW-1:0] run_mask, fill_word;

  always_comb begin
    for (int i = 0; i < WordW; i++) begin
      run_mask[i]  = ({mw_q, 6'(i)} >= lo_bit_q) && ({mw_q, 6'(i)} <= hi_bit_q);
      fill_word[i] = (req_q.mode == bpa_pkg::MODE_BLOCKS) ||
                     (bpa_pkg::CountW'({wrd_q, 6'(i)}) < pages);
    end
  end

  // End of a freed run, clipped at the end of its block.
  logic [bpa_pkg::CountW:0] end_sum;
  logic [BitW-1:0]          clear_hi;

  assign end_sum  = (bpa_pkg::CountW + 1)'(req_q.page_address[BitW-1:0]) +
                    (bpa_pkg::CountW + 1)'(pages);
  assign clear_hi = (end_sum > (bpa_pkg::CountW + 1)'(bpa_pkg::PagesPerBlock)) ?
                    BitW'(bpa_pkg::PagesPerBlock - 1) : BitW'(end_sum - 1'b1);

  // Binary search midpoint; the difference is never negative when used.
  logic signed [CntW:0] bs_diff, mid_v;
  logic                 bs_empty;

  assign bs_diff  = bs_hi_q - bs_lo_q;
  assign mid_v    = bs_lo_q + (bs_diff >>> 1);
  assign bs_empty = bs_lo_q > bs_hi_q;

  // Table move and fill indexes.
  logic [CntW-1:0] src_v;
  logic [SumW-1:0] dst_v, fill_v;

  assign src_v  = sh_q - CntW'(1);
  assign dst_v  = SumW'(src_v) + SumW'(n_v);
  assign fill_v = SumW'(pos_q) + SumW'(k_q);

  always_comb begin
    b_raddr = '0;
    u_raddr = '0;
    b_we    = 1'b0;
    u_we    = 1'b0;
    b_waddr = '0;
    u_waddr = '0;
    b_wdata = '0;
    u_wdata = '0;
    case (cmd_i)
      bpa_pkg::CMD_SCAN_RD: u_raddr = {blk_q[IdxW-1:0], wrd_q};
      bpa_pkg::CMD_BASE_RD: b_raddr = tgt_q;
      bpa_pkg::CMD_MARK_RD: u_raddr = {tgt_q, mw_q};
      bpa_pkg::CMD_MARK_WR: begin
        u_we    = 1'b1;
        u_waddr = {tgt_q, mw_q};
        u_wdata = set_q ? (u_rdata | run_mask) : (u_rdata & ~run_mask);
      end
      bpa_pkg::CMD_POS_RD: b_raddr = i_q[IdxW-1:0];
      bpa_pkg::CMD_COPY_RD: begin
        b_raddr = src_v[IdxW-1:0];
        u_raddr = {src_v[IdxW-1:0], wrd_q};
      end
      bpa_pkg::CMD_COPY_WR: begin
        b_we    = 1'b1;
        b_waddr = dst_v[IdxW-1:0];
        b_wdata = b_rdata;
        u_we    = 1'b1;
        u_waddr = {dst_v[IdxW-1:0], wrd_q};
        u_wdata = u_rdata;
      end
      bpa_pkg::CMD_FILL: begin
        b_we    = 1'b1;
        b_waddr = fill_v[IdxW-1:0];
        b_wdata = spare + FrameW'(k_q);
        u_we    = 1'b1;
        u_waddr = {fill_v[IdxW-1:0], wrd_q};
        u_wdata = fill_word;
      end
      bpa_pkg::CMD_BS_RD: b_raddr = mid_v[IdxW-1:0];
      default: ;
    endcase
  end

  logic fill_last;
  assign fill_last = (k_q == n_v - bpa_pkg::BlocksW'(1)) && (wrd_q == '1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == bpa_pkg::CMD_PUBLISH) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (cmd_i == bpa_pkg::CMD_FILL && fill_last) begin
        count_q <= CntW'(room_sum);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bpa_pkg::CMD_CAPTURE: req_q <= in_data_i;
      bpa_pkg::CMD_DECODE: begin
        blk_q               <= '0;
        wrd_q               <= '0;
        sub_q               <= '0;
        run_q               <= '0;
        i_q                 <= '0;
        bs_lo_q             <= '0;
        bs_hi_q             <= $signed({1'b0, count_q}) - BsOne;
        res_q.status        <= decode_status;
        res_q.granted_page  <= '0;
        res_q.used_spare    <= 1'b0;
      end
      bpa_pkg::CMD_SCAN_CAP: begin
        word_q <= u_rdata;
        sub_q  <= '0;
      end
      bpa_pkg::CMD_SCAN_CHUNK: begin
        if (fnd_v) begin
          lo_bit_q <= start_v;
          hi_bit_q <= j_v;
          set_q    <= 1'b1;
          mw_q     <= start_v[BitW-1 -: WSelW];
          tgt_q    <= blk_q[IdxW-1:0];
        end else begin
          // A run never carries over from one block into the next.
          run_q <= (sub_q == '1 && wrd_q == '1) ? '0 : run_v;
          sub_q <= sub_q + SubW'(1);
          if (sub_q == '1) begin
            wrd_q <= wrd_q + WSelW'(1);
            if (wrd_q == '1) begin
              blk_q <= blk_q + CntW'(1);
            end
          end
        end
      end
      bpa_pkg::CMD_GRANT: res_q.granted_page <= {b_rdata, lo_bit_q};
      bpa_pkg::CMD_MARK_WR: mw_q <= mw_q + WSelW'(1);
      bpa_pkg::CMD_ROOM: begin
        if (no_room) res_q.status <= bpa_pkg::STATUS_FULL;
        i_q <= '0;
      end
      bpa_pkg::CMD_POS_RD: begin
        if (i_q == count_q) begin
          pos_q <= i_q;
          sh_q  <= count_q;
          wrd_q <= '0;
          k_q   <= '0;
        end
      end
      bpa_pkg::CMD_POS_CHK: begin
        if (b_rdata > spare) begin
          pos_q <= i_q;
          sh_q  <= count_q;
          wrd_q <= '0;
          k_q   <= '0;
        end else begin
          i_q <= i_q + CntW'(1);
        end
      end
      bpa_pkg::CMD_COPY_WR: begin
        wrd_q <= wrd_q + WSelW'(1);
        if (wrd_q == '1) sh_q <= src_v;
      end
      bpa_pkg::CMD_FILL: begin
        wrd_q <= wrd_q + WSelW'(1);
        if (wrd_q == '1) k_q <= k_q + bpa_pkg::BlocksW'(1);
        if (fill_last) begin
          res_q.granted_page <= {spare, BitW'(0)};
          res_q.used_spare   <= 1'b1;
        end
      end
      bpa_pkg::CMD_BS_RD: begin
        if (bs_empty) res_q.status <= bpa_pkg::STATUS_NOT_FOUND;
        else mid_q <= mid_v;
      end
      bpa_pkg::CMD_BS_CMP: begin
        if (frame < b_rdata) begin
          bs_hi_q <= mid_q - BsOne;
        end else if (frame > b_rdata) begin
          bs_lo_q <= mid_q + BsOne;
        end else begin
          tgt_q    <= mid_q[IdxW-1:0];
          lo_bit_q <= req_q.page_address[BitW-1:0];
          hi_bit_q <= clear_hi;
          set_q    <= 1'b0;
          mw_q     <= req_q.page_address[BitW-1 -: WSelW];
        end
      end
      bpa_pkg::CMD_PUBLISH: out_q <= res_q;
      default: ;
    endcase
  end

  bpa_ram #(
    .Width(FrameW),
    .Depth(MaxBlocks)
  ) u_base_ram (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  bpa_ram #(
    .Width(WordW),
    .Depth(MaxBlocks * bpa_pkg::WordsPerBlock)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (u_we),
    .waddr_i(u_waddr),
    .wdata_i(u_wdata),
    .raddr_i(u_raddr),
    .rdata_o(u_rdata)
  );

  always_comb begin
    status_o.mode        = req_q.mode;
    status_o.reject      = decode_status != bpa_pkg::STATUS_DONE;
    status_o.count_zero  = count_q == '0;
    status_o.chunk_found = fnd_v;
    status_o.sub_last    = sub_q == '1;
    status_o.word_last   = wrd_q == '1;
    status_o.blk_last    = (blk_q + CntW'(1)) == count_q;
    status_o.no_room     = no_room;
    status_o.pos_at_end  = i_q == count_q;
    status_o.pos_hit     = b_rdata > spare;
    status_o.shift_done  = sh_q == pos_q;
    status_o.fill_last   = fill_last;
    status_o.bs_empty    = bs_empty;
    status_o.bs_equal    = frame == b_rdata;
    status_o.free_empty  = pages == '0;
    status_o.mark_last   = mw_q == hi_bit_q[BitW-1 -: WSelW];
    status_o.out_busy    = out_valid_q && out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/bitmap_page_allocator_unit.sv
// Top level of the first-fit bitmap page allocator: sequencer plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath (and bpa_ram below it).
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+------------------------
//   in      | into unit | in_valid_i / in_stall_o  | in_data_i  (bpa_pkg::req_t)
//   out     | from unit | out_valid_o / out_stall_i| out_data_o (bpa_pkg::rsp_t)
//
// One request is worked on at a time. A small allocation reads each 64-bit map
// word and scans it in 8-bit chunks until a run fits, then marks the run word
// by word; an insertion searches the table for its position, moves later
// entries up and fills each new block. A free binary-searches the table, then
// clears the run word by word.
// Reset clears the block count and the output valid flag; the table and map
// memories are left as they are, since no unwritten entry's value is used.
// A finished result waits in the output register, so the next request is
// taken while the result is still stalled; a request only stalls in its last
// step if the previous result has not yet been taken.
module bitmap_page_allocator_unit #(
  parameter int MAX_BLOCKS = bpa_pkg::MaxBlocksDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bpa_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bpa_pkg::rsp_t out_data_o
);

  bpa_pkg::cmd_e       cmd;
  bpa_pkg::dp_status_t dp_status;

  // The sequencer decides the step; the datapath carries it out and reports
  // the conditions that choose the next one.
  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (dp_status),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  bpa_datapath #(
    .MaxBlocks(MAX_BLOCKS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .status_o   (dp_status)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction keeps the unit busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("unit free again right after accepting a transaction");

  // A consumed spare only comes with a successful allocation.
  a_spare_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.used_spare |->
      out_data_o.status == bpa_pkg::STATUS_DONE)
    else $error("spare reported used on a failed request");

  // A failed request grants no page.
  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != bpa_pkg::STATUS_DONE |->
      out_data_o.granted_page == '0 && !out_data_o.used_spare)
    else $error("failed request carries a grant");
`endif

endmodule

FILE: verif/tb_bitmap_page_allocator_unit.sv
// Testbench of bitmap_page_allocator_unit: directed and random requests, with a
// scoreboard that predicts every response. Depends on bpa_pkg and the unit.
module tb_bitmap_page_allocator_unit;

  localparam int ModeW         = bpa_pkg::ModeW;
  localparam int CountW        = bpa_pkg::CountW;
  localparam int PageW         = bpa_pkg::PageW;
  localparam int FrameW        = bpa_pkg::FrameW;
  localparam int BitW          = bpa_pkg::BitW;
  localparam int PagesPerBlock = bpa_pkg::PagesPerBlock;

  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int NumBlocks   = bpa_pkg::MaxBlocksDef;
  localparam int RandomItems = 830;
  // Worst single request: a full table scan plus a long insertion shift; the
  // limit lies well above it and above the long receiver hold-off.
  localparam int IdleLimit   = 40000;
  localparam int HoldCycles  = 500;

  // Scoreboard: its own copy of the block table and page maps. Each accepted
  // request is applied to that copy, and the expected response is queued.
  class alloc_scoreboard;
    logic [FrameW-1:0]        base [NumBlocks];
    logic [PagesPerBlock-1:0] usage [NumBlocks];
    int                       count;
    bpa_pkg::rsp_t            rsp_q [$];
    logic [PageW-1:0]         run_addr_q [$];
    int                       run_len_q [$];
    int                       errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Puts n blocks in sorted position, after any entry with an equal or
    // lower frame; returns the index of the first new entry.
    function automatic int insert_blocks(logic [FrameW-1:0] spare, int n, bit full);
      int pos;
      pos = count;
      for (int i = 0; i < count; i++) begin
        if (base[i] > spare) begin
          pos = i;
          break;
        end
      end
      for (int i = count; i > pos; i--) begin
        base[i-1+n]  = base[i-1];
        usage[i-1+n] = usage[i-1];
      end
      for (int k = 0; k < n; k++) begin
        base[pos+k]  = spare + FrameW'(k);
        usage[pos+k] = full ? '1 : '0;
      end
      count += n;
      return pos;
    endfunction

    function automatic void note_request(bpa_pkg::req_t r);
      bpa_pkg::rsp_t     e;
      int                pages, run, start, n, lo, hi, mid, hit, pos, stop;
      bit                found;
      logic [FrameW-1:0] frame;
      e     = '0;
      e.status = bpa_pkg::STATUS_DONE;
      pages = int'(r.page_count);
      if (r.mode == bpa_pkg::MODE_PAGES) begin
        if (pages == 0 || pages > PagesPerBlock) begin
          e.status = bpa_pkg::STATUS_TOO_LARGE;
        end else begin
          found = 0;
          for (int b = 0; b < count && !found; b++) begin
            run = 0;
            for (int j = 0; j < PagesPerBlock; j++) begin
              run = usage[b][j] ? 0 : run + 1;
              if (run == pages) begin
                start = j + 1 - pages;
                for (int k = start; k <= j; k++) usage[b][k] = 1'b1;
                e.granted_page = {base[b], BitW'(start)};
                found = 1;
                break;
              end
            end
          end
          if (!found) begin
            if (count + 1 > NumBlocks) begin
              e.status = bpa_pkg::STATUS_FULL;
            end else begin
              pos = insert_blocks(r.spare_block, 1, 0);
              for (int k = 0; k < pages; k++) usage[pos][k] = 1'b1;
              e.granted_page = {r.spare_block, BitW'(0)};
              e.used_spare   = 1'b1;
            end
          end
          if (e.status == bpa_pkg::STATUS_DONE) begin
            run_addr_q.push_back(e.granted_page);
            run_len_q.push_back(pages);
          end
        end
      end else if (r.mode == bpa_pkg::MODE_BLOCKS) begin
        n = (pages + PagesPerBlock - 1) / PagesPerBlock;
        if (n == 0) begin
          e.status = bpa_pkg::STATUS_TOO_LARGE;
        end else if (count + n > NumBlocks) begin
          e.status = bpa_pkg::STATUS_FULL;
        end else begin
          pos = insert_blocks(r.spare_block, n, 1);
          e.granted_page = {r.spare_block, BitW'(0)};
          e.used_spare   = 1'b1;
        end
      end else if (r.mode == bpa_pkg::MODE_FREE) begin
        frame = r.page_address[PageW-1:BitW];
        lo    = 0;
        hi    = count - 1;
        hit   = -1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (frame < base[mid]) hi = mid - 1;
          else if (frame > base[mid]) lo = mid + 1;
          else begin
            hit = mid;
            break;
          end
        end
        if (hit < 0) begin
          e.status = bpa_pkg::STATUS_NOT_FOUND;
        end else begin
          pos  = int'(r.page_address[BitW-1:0]);
          stop = pos + pages;
          if (stop > PagesPerBlock) stop = PagesPerBlock;
          for (int k = pos; k < stop; k++) usage[hit][k] = 1'b0;
        end
      end else begin
        e.status = bpa_pkg::STATUS_TOO_LARGE;
      end
      rsp_q.push_back(e);
    endfunction

    function automatic void check_response(bpa_pkg::rsp_t a);
      bpa_pkg::rsp_t e;
      if (rsp_q.size() == 0) begin
        $error("response with nothing expected: status %0d granted_page %0h",
               a.status, a.granted_page);
        errors++;
        return;
      end
      e = rsp_q.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, a.status);
        errors++;
      end
      if (a.granted_page !== e.granted_page) begin
        $error("granted_page: expected %0h, actual %0h", e.granted_page, a.granted_page);
        errors++;
      end
      if (a.used_spare !== e.used_spare) begin
        $error("used_spare: expected %0d, actual %0d", e.used_spare, a.used_spare);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  bpa_pkg::req_t in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bpa_pkg::rsp_t out_data;

  alloc_scoreboard sb = new();
  int    tx_idle_pct = 29;
  int    rx_idle_pct = 59;
  int    responses   = 0;

  bitmap_page_allocator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Offers one request, idling first as the current phase asks, and hands it
  // to the scoreboard once the transaction has happened.
  task automatic send_request(bpa_pkg::req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(r);
  endtask

  function automatic bpa_pkg::req_t make_req(logic [ModeW-1:0] m, logic [CountW-1:0] c,
                                             logic [PageW-1:0] a, logic [FrameW-1:0] s);
    bpa_pkg::req_t r;
    r.mode         = m;
    r.page_count   = c;
    r.page_address = a;
    r.spare_block  = s;
    return r;
  endfunction

  // Spare frames are a mix of wide random values, a narrow band so that inserts
  // land between held blocks, frames equal to a held block and the top frame.
  function automatic logic [FrameW-1:0] pick_spare();
    int r;
    r = $urandom_range(99);
    if (r < 45) return FrameW'({$urandom, $urandom});
    if (r < 80 || sb.count == 0) return FrameW'($urandom_range(4000));
    if (r < 95) return sb.base[$urandom_range(sb.count - 1)];
    return '1;
  endfunction

  function automatic bpa_pkg::req_t random_req();
    int                r, idx;
    logic [CountW-1:0] c;
    r = $urandom_range(99);
    if (sb.count >= 48 && r < 45) r = 50;
    if (r < 45) begin
      c = ($urandom_range(3) != 0) ? CountW'($urandom_range(1, 16))
                                   : CountW'($urandom_range(1, PagesPerBlock));
      return make_req(bpa_pkg::MODE_PAGES, c, PageW'({$urandom, $urandom}), pick_spare());
    end
    if (r < 75 && sb.run_addr_q.size() > 0) begin
      // Release a run handed out earlier, now and then only part of it.
      idx = $urandom_range(sb.run_addr_q.size() - 1);
      c   = CountW'(sb.run_len_q[idx]);
      if ($urandom_range(9) == 0) c = CountW'($urandom_range(0, sb.run_len_q[idx]));
      make_req_free: begin
        bpa_pkg::req_t f;
        f = make_req(bpa_pkg::MODE_FREE, c, sb.run_addr_q[idx], pick_spare());
        sb.run_addr_q.delete(idx);
        sb.run_len_q.delete(idx);
        return f;
      end
    end
    if (r < 82) begin
      c = ($urandom_range(9) != 0) ? CountW'($urandom_range(1, 1536)) : CountW'($urandom);
      return make_req(bpa_pkg::MODE_BLOCKS, c, PageW'({$urandom, $urandom}), pick_spare());
    end
    if (r < 90 && sb.count > 0) begin
      return make_req(bpa_pkg::MODE_FREE, CountW'($urandom_range(600)),
                      {sb.base[$urandom_range(sb.count - 1)], BitW'($urandom)},
                      pick_spare());
    end
    return make_req(ModeW'($urandom_range(3)), CountW'($urandom),
                    PageW'({$urandom, $urandom}), FrameW'({$urandom, $urandom}));
  endfunction

  // Stimulus: directed corner cases first, then three idling phases.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd0, '0, 43'd10));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd513, '0, 43'd10));
    send_request(make_req(bpa_pkg::MODE_BLOCKS, 16'd0, '0, 43'd10));
    send_request(make_req(MODE_UNUSED, 16'd1, '1, '1));
    send_request(make_req(bpa_pkg::MODE_FREE, 16'd1, {43'd100, 9'd0}, '0));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd1, '0, 43'd100));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd512, '0, 43'd50));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd511, '0, 43'd200));
    // Two whole blocks from the top frame wrap round to frame zero.
    send_request(make_req(bpa_pkg::MODE_BLOCKS, 16'd1024, '0, '1));
    send_request(make_req(bpa_pkg::MODE_FREE, 16'd0, {43'd100, 9'd0}, '0));
    send_request(make_req(bpa_pkg::MODE_FREE, 16'd100, {43'd100, 9'd500}, '0));
    send_request(make_req(bpa_pkg::MODE_FREE, 16'hFFFF, {43'd100, 9'd0}, '0));
    send_request(make_req(bpa_pkg::MODE_FREE, 16'd3, '1, '0));
    send_request(make_req(bpa_pkg::MODE_FREE, 16'd3, {43'd12345, 9'd7}, '0));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd512, '0, 43'd100));
    send_request(make_req(bpa_pkg::MODE_BLOCKS, 16'd32768, '0, 43'd9000));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'hFFFF, '0, 43'd10));
    send_request(make_req(bpa_pkg::MODE_BLOCKS, 16'd513, '0, 43'd7));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd3, '0, 43'd0));
    send_request(make_req(bpa_pkg::MODE_PAGES, 16'd1, '0, 43'd3));
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) begin
        tx_idle_pct = 59;
        rx_idle_pct = 29;
      end else if (i == 2 * RandomItems / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_request(random_req());
    end
    in_valid <= 1'b0;
    while (sb.rsp_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("bitmap_page_allocator_unit: match");
    end else begin
      $display("bitmap_page_allocator_unit: mismatch");
    end
    $finish;
  end

  // Response side: checks every accepted transaction and stalls at random.
  // Once, in the phase without idling, it holds off long enough for the unit
  // to fill its output register and stall the request channel.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        sb.check_response(out_data);
        responses++;
        if (responses == 2 * RandomItems / 3 + 40) hold = HoldCycles;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no transaction happens on either channel for
  // too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("bitmap_page_allocator_unit: mismatch");
        $finish;
      end
    end
  end

endmodule
